// ----- rtl/core/ltte_pkg.sv -----
package ltte_pkg;

	// characters of the stamp pattern
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// parser position codes; 1..21 point one past the next field offset
	localparam logic [4:0] POS_WAIT  = 5'd0;
	localparam logic [4:0] POS_FIRST = 5'd1;
	localparam logic [4:0] POS_LAST  = 5'd21;
	localparam logic [4:0] POS_DONE  = 5'd22;
	localparam logic [4:0] POS_DEAD  = 5'd31;

	localparam int MONTHS = 12;
	localparam logic [3:0] MONTH_MAR = 4'd2;

	localparam logic [23:0] MONTH_NAME [MONTHS] = '{
		"Jan", "Feb", "Mar", "Apr", "May", "Jun",
		"Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
	};

	// day of year of day zero of each month in a common year, minus one
	localparam logic signed [9:0] DAY_BASE [MONTHS] = '{
		-10'sd1, 10'sd30, 10'sd58, 10'sd89, 10'sd119, 10'sd150,
		10'sd180, 10'sd211, 10'sd242, 10'sd272, 10'sd303, 10'sd333
	};

	localparam logic signed [15:0] EPOCH_YEAR   = 16'sd1970;
	localparam logic signed [23:0] DAYS_PER_YR  = 24'sd365;
	localparam logic signed [23:0] LEAPS_TO_EPOCH = 24'sd477;
	localparam logic signed [39:0] SECS_PER_DAY = 40'sd86400;
	localparam logic [18:0] SECS_PER_HOUR = 19'd3600;
	localparam logic [18:0] SECS_PER_MIN  = 19'd60;

	localparam int EPOCH_W = 39;

	typedef struct packed {
		logic       ok;
		logic [6:0] day_value;
		logic [3:0] month_index;
		logic [6:0] year_hi;
		logic [6:0] year_lo;
		logic [6:0] hour_value;
		logic [6:0] minute_value;
		logic [6:0] second_value;
	} ltte_fields_t;

endpackage

// ----- rtl/core/ltte_if.sv -----
interface ltte_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       line_end;

	modport source(output valid, text_byte, line_end, input ready);
	modport sink(input valid, text_byte, line_end, output ready);
endinterface

interface ltte_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [ltte_pkg::EPOCH_W-1:0] epoch_seconds;
	logic                                stamp_valid;

	modport source(output valid, epoch_seconds, stamp_valid, input ready);
	modport sink(input valid, epoch_seconds, stamp_valid, output ready);
endinterface

// ----- rtl/core/ltte_parse.sv -----
module ltte_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	ltte_in_if.sink               text_in,
	output ltte_pkg::ltte_fields_t fields_s1,
	output logic                  v_s1
);

	localparam logic [4:0] OFF_DAY0   = 5'd0;
	localparam logic [4:0] OFF_DAY1   = 5'd1;
	localparam logic [4:0] OFF_SLASH1 = 5'd2;
	localparam logic [4:0] OFF_MON0   = 5'd3;
	localparam logic [4:0] OFF_MON1   = 5'd4;
	localparam logic [4:0] OFF_MON2   = 5'd5;
	localparam logic [4:0] OFF_SLASH2 = 5'd6;
	localparam logic [4:0] OFF_YEAR0  = 5'd7;
	localparam logic [4:0] OFF_YEAR1  = 5'd8;
	localparam logic [4:0] OFF_YEAR2  = 5'd9;
	localparam logic [4:0] OFF_YEAR3  = 5'd10;
	localparam logic [4:0] OFF_COLON1 = 5'd11;
	localparam logic [4:0] OFF_HOUR0  = 5'd12;
	localparam logic [4:0] OFF_HOUR1  = 5'd13;
	localparam logic [4:0] OFF_COLON2 = 5'd14;
	localparam logic [4:0] OFF_MIN0   = 5'd15;
	localparam logic [4:0] OFF_MIN1   = 5'd16;
	localparam logic [4:0] OFF_COLON3 = 5'd17;
	localparam logic [4:0] OFF_SEC0   = 5'd18;
	localparam logic [4:0] OFF_SEC1   = 5'd19;

	logic       acc;
	logic [7:0] b;
	logic [4:0] pos_q, pos_n;
	logic       err_q, err_n;
	logic [6:0] day_q, day_n;
	logic [7:0] mc0_q, mc0_n;
	logic [7:0] mc1_q, mc1_n;
	logic [3:0] mon_q, mon_n;
	logic [6:0] yhi_q, yhi_n;
	logic [6:0] ylo_q, ylo_n;
	logic [6:0] hour_q, hour_n;
	logic [6:0] min_q, min_n;
	logic [6:0] sec_q, sec_n;
	logic [4:0] k;
	logic       is_dig;
	logic [6:0] dig;
	logic       mon_hit;
	logic [3:0] mon_idx;
	ltte_pkg::ltte_fields_t fields_c;

	assign b   = text_in.text_byte;
	assign acc = text_in.valid && adv;
	assign text_in.ready = adv;

	always_comb begin
		is_dig = (b >= ltte_pkg::CH_ZERO) && (b <= ltte_pkg::CH_NINE);
		dig    = is_dig ? 7'(b - ltte_pkg::CH_ZERO) : 7'd0;
		k      = pos_q - 5'd1;
		mon_hit = 1'b0;
		mon_idx = '0;
		for (int i = 0; i < ltte_pkg::MONTHS; i++) begin
			if ({mc0_q, mc1_q, b} == ltte_pkg::MONTH_NAME[i]) begin
				mon_hit = 1'b1;
				mon_idx = 4'(i);
			end
		end
	end

	always_comb begin
		pos_n  = pos_q;
		err_n  = err_q;
		day_n  = day_q;
		mc0_n  = mc0_q;
		mc1_n  = mc1_q;
		mon_n  = mon_q;
		yhi_n  = yhi_q;
		ylo_n  = ylo_q;
		hour_n = hour_q;
		min_n  = min_q;
		sec_n  = sec_q;
		if (pos_q == ltte_pkg::POS_WAIT) begin
			if (b == ltte_pkg::CH_LBRACK)
				pos_n = ltte_pkg::POS_FIRST;
			else if (b == ltte_pkg::CH_NUL)
				pos_n = ltte_pkg::POS_DEAD;
		end else if (pos_q <= ltte_pkg::POS_LAST) begin
			pos_n = pos_q + 5'd1;
			case (k) inside
				OFF_DAY0, OFF_DAY1: begin
					day_n = 7'(day_q * 7'd10) + dig;
					if (!is_dig) err_n = 1'b1;
				end
				OFF_MON0: mc0_n = b;
				OFF_MON1: mc1_n = b;
				OFF_MON2: begin
					mon_n = mon_idx;
					if (!mon_hit) err_n = 1'b1;
				end
				OFF_SLASH1, OFF_SLASH2: begin
					if (b != ltte_pkg::CH_SLASH) err_n = 1'b1;
				end
				OFF_YEAR0, OFF_YEAR1: begin
					yhi_n = 7'(yhi_q * 7'd10) + dig;
					if (!is_dig) err_n = 1'b1;
				end
				OFF_YEAR2, OFF_YEAR3: begin
					ylo_n = 7'(ylo_q * 7'd10) + dig;
					if (!is_dig) err_n = 1'b1;
				end
				OFF_COLON1, OFF_COLON2, OFF_COLON3: begin
					if (b != ltte_pkg::CH_COLON) err_n = 1'b1;
				end
				OFF_HOUR0, OFF_HOUR1: begin
					hour_n = 7'(hour_q * 7'd10) + dig;
					if (!is_dig) err_n = 1'b1;
				end
				OFF_MIN0, OFF_MIN1: begin
					min_n = 7'(min_q * 7'd10) + dig;
					if (!is_dig) err_n = 1'b1;
				end
				OFF_SEC0, OFF_SEC1: begin
					sec_n = 7'(sec_q * 7'd10) + dig;
					if (!is_dig) err_n = 1'b1;
				end
				default: begin
					if (b != ltte_pkg::CH_SPACE) err_n = 1'b1;
				end
			endcase
		end
		fields_c.ok           = (pos_n == ltte_pkg::POS_DONE) && !err_n;
		fields_c.day_value    = day_n;
		fields_c.month_index  = mon_n;
		fields_c.year_hi      = yhi_n;
		fields_c.year_lo      = ylo_n;
		fields_c.hour_value   = hour_n;
		fields_c.minute_value = min_n;
		fields_c.second_value = sec_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= ltte_pkg::POS_WAIT;
			err_q  <= 1'b0;
			day_q  <= '0;
			mc0_q  <= '0;
			mc1_q  <= '0;
			mon_q  <= '0;
			yhi_q  <= '0;
			ylo_q  <= '0;
			hour_q <= '0;
			min_q  <= '0;
			sec_q  <= '0;
		end else if (acc) begin
			if (text_in.line_end) begin
				// line done: start over for the next line
				pos_q  <= ltte_pkg::POS_WAIT;
				err_q  <= 1'b0;
				day_q  <= '0;
				mc0_q  <= '0;
				mc1_q  <= '0;
				mon_q  <= '0;
				yhi_q  <= '0;
				ylo_q  <= '0;
				hour_q <= '0;
				min_q  <= '0;
				sec_q  <= '0;
			end else begin
				pos_q  <= pos_n;
				err_q  <= err_n;
				day_q  <= day_n;
				mc0_q  <= mc0_n;
				mc1_q  <= mc1_n;
				mon_q  <= mon_n;
				yhi_q  <= yhi_n;
				ylo_q  <= ylo_n;
				hour_q <= hour_n;
				min_q  <= min_n;
				sec_q  <= sec_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= text_in.valid && text_in.line_end;
	end

	always_ff @(posedge clk) begin
		if (adv)
			fields_s1 <= fields_c;
	end

	a_pos_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!((pos_q > ltte_pkg::POS_DONE) && (pos_q < ltte_pkg::POS_DEAD)))
		else $error("parser position out of range");

	a_line_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && text_in.line_end) |=> (pos_q == ltte_pkg::POS_WAIT) && !err_q && v_s1)
		else $error("line end did not restart parser or launch result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !(text_in.valid && text_in.line_end)) |=> !v_s1)
		else $error("result launched without a line end beat");

endmodule

// ----- rtl/core/ltte_calc.sv -----
module ltte_calc (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ltte_pkg::ltte_fields_t fields_s1,
	input  logic                   v_s1,
	output logic                   adv,
	ltte_out_if.source             stamp_out
);

	logic        v_s2, v_s3, v_s4;
	logic        ok_s2, ok_s3;
	logic [13:0] y_s2;
	logic signed [7:0]  cp_s2;
	logic signed [9:0]  dpart_s2;
	logic [18:0] tod_s2, tod_s3;
	logic signed [23:0] days_s3;
	logic        stamp_s4;
	logic signed [ltte_pkg::EPOCH_W-1:0] epoch_s4;

	logic [13:0] y_c;
	logic        leap_c;
	logic        leap_adj;
	logic signed [7:0]  cp_c;
	logic signed [9:0]  dpart_c;
	logic [18:0] tod_c;
	logic signed [15:0] yoff;
	logic signed [15:0] ym1;
	logic signed [15:0] q4;
	logic signed [7:0]  cp4;
	logic signed [23:0] days_c;
	logic signed [39:0] prod;

	assign adv = !v_s4 || stamp_out.ready;

	// year-derived terms, day within year, time of day
	always_comb begin
		y_c = 14'(fields_s1.year_hi * 14'd100) + 14'(fields_s1.year_lo);
		leap_c = (fields_s1.year_lo[1:0] == 2'b00) &&
			((fields_s1.year_lo != 7'd0) || (fields_s1.year_hi[1:0] == 2'b00));
		leap_adj = leap_c && (fields_s1.month_index >= ltte_pkg::MONTH_MAR);
		// floor((y-1)/100)
		cp_c = (fields_s1.year_lo != 7'd0) ? $signed({1'b0, fields_s1.year_hi}) :
			$signed({1'b0, fields_s1.year_hi}) - 8'sd1;
		dpart_c = ltte_pkg::DAY_BASE[fields_s1.month_index] +
			$signed({3'b000, fields_s1.day_value}) + $signed({9'd0, leap_adj});
		tod_c = 19'(fields_s1.hour_value) * ltte_pkg::SECS_PER_HOUR +
			19'(fields_s1.minute_value) * ltte_pkg::SECS_PER_MIN +
			19'(fields_s1.second_value);
	end

	// days since epoch: leap days in 1..y-1 by floor divisions
	always_comb begin
		yoff = $signed({2'b00, y_s2}) - ltte_pkg::EPOCH_YEAR;
		ym1  = $signed({2'b00, y_s2}) - 16'sd1;
		q4   = ym1 >>> 2;
		cp4  = cp_s2 >>> 2;
		days_c = $signed({{8{yoff[15]}}, yoff}) * ltte_pkg::DAYS_PER_YR +
			$signed({{8{q4[15]}}, q4}) -
			$signed({{16{cp_s2[7]}}, cp_s2}) +
			$signed({{16{cp4[7]}}, cp4}) -
			ltte_pkg::LEAPS_TO_EPOCH +
			$signed({{14{dpart_s2[9]}}, dpart_s2});
	end

	always_comb begin
		prod = $signed({{16{days_s3[23]}}, days_s3}) * ltte_pkg::SECS_PER_DAY +
			$signed({21'd0, tod_s3});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s2    <= fields_s1.ok;
			y_s2     <= y_c;
			cp_s2    <= cp_c;
			dpart_s2 <= dpart_c;
			tod_s2   <= tod_c;
			ok_s3    <= ok_s2;
			days_s3  <= days_c;
			tod_s3   <= tod_s2;
			stamp_s4 <= ok_s3;
			epoch_s4 <= ok_s3 ? prod[ltte_pkg::EPOCH_W-1:0] : '0;
		end
	end

	assign stamp_out.valid         = v_s4;
	assign stamp_out.epoch_seconds = epoch_s4;
	assign stamp_out.stamp_valid   = stamp_s4;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !stamp_s4) |-> (epoch_s4 == '0))
		else $error("invalid stamp with nonzero seconds");

	a_stage_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s3) |=> v_s4)
		else $error("result lost between last stages");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> v_s4 && $stable(v_s3) && $stable(v_s2))
		else $error("pipeline moved during stall");

endmodule

// ----- rtl/core/log_timestamp_to_epoch.sv -----
// channel    dir  fields                         accepted when
// text_in    in   text_byte[7:0], line_end       text_in.valid && text_in.ready
// stamp_out  out  epoch_seconds[38:0] (signed),  stamp_out.valid && stamp_out.ready
//                 stamp_valid
//
// One text beat per cycle unless a result is stalled. The line-end beat's result passes
// the parse register and then three arithmetic stages (year terms, day count, seconds
// multiply), all advancing together.
// arst_n clears the parser to wait for '[' and empties the pipeline.
// A stalled result holds the whole pipeline; text_in.ready drops only then.
module log_timestamp_to_epoch (
	input  logic       clk,
	input  logic       arst_n,
	ltte_in_if.sink    text_in,
	ltte_out_if.source stamp_out
);

	logic                   adv;
	logic                   v_s1;
	ltte_pkg::ltte_fields_t fields_s1;

	ltte_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.text_in   (text_in),
		.fields_s1 (fields_s1),
		.v_s1      (v_s1)
	);

	ltte_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.fields_s1 (fields_s1),
		.v_s1      (v_s1),
		.adv       (adv),
		.stamp_out (stamp_out)
	);

endmodule

// ----- verif/tb_log_timestamp_to_epoch.sv -----
`timescale 1ns / 100ps

module tb_log_timestamp_to_epoch;

	localparam int HOLD_CYCLES = 80;

	typedef struct {
		logic [ltte_pkg::EPOCH_W-1:0] secs;
		logic                         ok;
	} stamp_t;

	typedef enum {GOOD_LINE, MUTATED_LINE, SHORT_LINE, BARE_LINE, DEAD_LINE} line_kind_t;

	logic clk = 1'b0;
	logic arst_n;
	logic holding = 1'b0;
	event hold_go;

	ltte_in_if  text_in();
	ltte_out_if stamp_out();

	log_timestamp_to_epoch DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in),
		.stamp_out(stamp_out)
	);

	always #5 clk = ~clk;

	string month_abbr [12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
		"Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};
	int month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	// parser copy kept in step with the block
	logic [4:0]  parse_pos;
	logic        fmt_err;
	logic [6:0]  day_acc;
	logic [15:0] month_pair;
	logic [3:0]  month_sel;
	logic [13:0] year_acc;
	logic [6:0]  hour_acc;
	logic [6:0]  min_acc;
	logic [6:0]  sec_acc;

	stamp_t     stamps_due[$];
	logic [7:0] line_buf[$];

	int gap_pct = 0;
	int stall_pct = 0;
	int mismatch_count = 0;
	int beats_sent = 0;
	int lines_sent = 0;
	int stamps_checked = 0;
	int valid_stamps = 0;

	function automatic void clear_parser();
		parse_pos = ltte_pkg::POS_WAIT;
		fmt_err = 1'b0;
		day_acc = '0;
		month_pair = '0;
		month_sel = '0;
		year_acc = '0;
		hour_acc = '0;
		min_acc = '0;
		sec_acc = '0;
	endfunction

	function automatic int unsigned digit_or_flag(logic [7:0] b);
		if (b < ltte_pkg::CH_ZERO || b > ltte_pkg::CH_NINE) begin
			fmt_err = 1'b1;
			return 0;
		end
		return 32'(b - ltte_pkg::CH_ZERO);
	endfunction

	function automatic void take_stamp_char(int k, logic [7:0] b);
		logic found;
		found = 1'b0;
		case (k)
			0, 1: day_acc = 7'(day_acc * 10 + digit_or_flag(b));
			2, 6: if (b != ltte_pkg::CH_SLASH) fmt_err = 1'b1;
			3: month_pair = {b, 8'h00};
			4: month_pair[7:0] = b;
			5: begin
				for (int i = 0; i < 12; i++) begin
					if (!found && month_abbr[i][0] == month_pair[15:8] &&
					    month_abbr[i][1] == month_pair[7:0] && month_abbr[i][2] == b) begin
						month_sel = 4'(i);
						found = 1'b1;
					end
				end
				if (!found) fmt_err = 1'b1;
			end
			7, 8, 9, 10: year_acc = 14'(year_acc * 10 + digit_or_flag(b));
			11, 14, 17: if (b != ltte_pkg::CH_COLON) fmt_err = 1'b1;
			12, 13: hour_acc = 7'(hour_acc * 10 + digit_or_flag(b));
			15, 16: min_acc = 7'(min_acc * 10 + digit_or_flag(b));
			18, 19: sec_acc = 7'(sec_acc * 10 + digit_or_flag(b));
			default: if (b != ltte_pkg::CH_SPACE) fmt_err = 1'b1;
		endcase
	endfunction

	// leap years in 1..n
	function automatic longint leap_total(longint n);
		return n / 4 - n / 100 + n / 400;
	endfunction

	function automatic logic [ltte_pkg::EPOCH_W-1:0] seconds_since_1970();
		longint y;
		longint days;
		longint total;
		longint base;
		int m;
		bit leap;
		y = longint'(year_acc);
		m = int'(month_sel) % 12;
		leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		base = -1;
		for (int i = 0; i < m; i++)
			base += month_len[i];
		// leap days from 1970 up to the year before; shift by 400 keeps n positive
		days = 365 * (y - 1970) + (leap_total(y + 399) - 97) - leap_total(1969);
		days += base + longint'(day_acc);
		if (leap && m >= 2)
			days += 1;
		total = days * 86400 + longint'(hour_acc) * 3600 + longint'(min_acc) * 60 +
			longint'(sec_acc);
		return total[ltte_pkg::EPOCH_W-1:0];
	endfunction

	function automatic void advance_parser(logic [7:0] b, logic last);
		stamp_t s;
		if (parse_pos == ltte_pkg::POS_WAIT) begin
			if (b == ltte_pkg::CH_LBRACK)
				parse_pos = ltte_pkg::POS_FIRST;
			else if (b == ltte_pkg::CH_NUL)
				parse_pos = ltte_pkg::POS_DEAD;
		end else if (parse_pos >= ltte_pkg::POS_FIRST && parse_pos <= ltte_pkg::POS_LAST) begin
			take_stamp_char(int'(parse_pos) - 1, b);
			parse_pos = parse_pos + 5'd1;
		end
		if (last) begin
			if (parse_pos == ltte_pkg::POS_DONE && !fmt_err) begin
				s.secs = seconds_since_1970();
				s.ok = 1'b1;
			end else begin
				s.secs = '0;
				s.ok = 1'b0;
			end
			stamps_due.push_back(s);
			clear_parser();
		end
	endfunction

	task automatic flag_mismatch(string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_stamp();
		stamp_t s;
		if (stamps_due.size() == 0) begin
			flag_mismatch($sformatf("result beat with nothing expected (secs %0d valid %0b)",
				stamp_out.epoch_seconds, stamp_out.stamp_valid));
		end else begin
			s = stamps_due.pop_front();
			stamps_checked++;
			if (s.ok)
				valid_stamps++;
			if (stamp_out.epoch_seconds !== s.secs)
				flag_mismatch($sformatf("epoch_seconds %0d, expected %0d",
					stamp_out.epoch_seconds, $signed(s.secs)));
			if (stamp_out.stamp_valid !== s.ok)
				flag_mismatch($sformatf("stamp_valid %b, expected %b",
					stamp_out.stamp_valid, s.ok));
		end
	endtask

	// result side: check each beat, then pick ready for the next edge
	initial begin
		stamp_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stamp_out.valid === 1'b1 && stamp_out.ready === 1'b1)
				check_stamp();
			stamp_out.ready <= !holding && ($urandom_range(99) >= stall_pct);
		end
	end

	// long output hold, counted here so the sender keeps pushing meanwhile
	initial begin
		forever begin
			@(hold_go);
			holding <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding <= 1'b0;
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < gap_pct) begin
			text_in.valid <= 1'b0;
			@(posedge clk);
		end
		text_in.valid <= 1'b1;
		text_in.text_byte <= b;
		text_in.line_end <= last;
		@(posedge clk);
		while (text_in.ready !== 1'b1)
			@(posedge clk);
		beats_sent++;
		advance_parser(b, last);
	endtask

	task automatic push_byte(input logic [7:0] b);
		line_buf.push_back(b);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++)
			send_beat(line_buf[i], i == line_buf.size() - 1);
		line_buf.delete();
		lines_sent++;
	endtask

	task automatic send_text_line(input string s);
		push_text(s);
		send_line();
	endtask

	function automatic string stamp_text(int d, int mon, int y, int h, int mi, int s);
		return $sformatf("%02d/%s/%04d:%02d:%02d:%02d ", d, month_abbr[mon], y, h, mi, s);
	endfunction

	function automatic string random_stamp_text();
		return stamp_text($urandom_range(99), $urandom_range(11), $urandom_range(9999),
			$urandom_range(99), $urandom_range(99), $urandom_range(99));
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == ltte_pkg::CH_LBRACK || b == ltte_pkg::CH_NUL);
		return b;
	endfunction

	// near misses hit the separator, digit and month checks more often than noise
	function automatic logic [7:0] bent_byte();
		string near;
		near = "0123456789/: JFMASONDjfmasondaceglnoprtuvby[";
		if ($urandom_range(1))
			return 8'($urandom_range(255));
		return near[$urandom_range(near.len() - 1)];
	endfunction

	task automatic random_line();
		int roll;
		int cut;
		int spot;
		string f;
		line_kind_t kind;
		roll = $urandom_range(99);
		kind = roll < 65 ? GOOD_LINE : roll < 80 ? MUTATED_LINE : roll < 88 ? SHORT_LINE :
			roll < 94 ? BARE_LINE : DEAD_LINE;
		if (kind == BARE_LINE) begin
			repeat ($urandom_range(1, 8))
				push_byte($urandom_range(3) == 0 ? ltte_pkg::CH_NUL : plain_byte());
			send_line();
			return;
		end
		if (kind == DEAD_LINE)
			push_byte(ltte_pkg::CH_NUL);
		repeat ($urandom_range(4))
			push_byte(plain_byte());
		push_byte(ltte_pkg::CH_LBRACK);
		f = random_stamp_text();
		case (kind)
			MUTATED_LINE: begin
				spot = $urandom_range(20);
				for (int i = 0; i < 21; i++)
					push_byte(i == spot ? bent_byte() : f[i]);
			end
			SHORT_LINE: begin
				cut = $urandom_range(20);
				for (int i = 0; i < cut; i++)
					push_byte(f[i]);
			end
			default: begin
				push_text(f);
				repeat ($urandom_range(3))
					push_byte(8'($urandom_range(255)));
			end
		endcase
		send_line();
	endtask

	task automatic test_known_stamps();
		send_text_line("[01/Jan/1970:00:00:00 ");
		push_byte(8'hFF);
		push_byte(8'h80);
		push_text("[29/Feb/2000:12:34:56 ]");
		send_line();
		send_text_line("[01/Mar/1900:00:00:00 ");
		send_text_line("[31/Dec/9999:23:59:59 ");
		send_text_line("[00/Jan/0000:00:00:00 ");
		send_text_line("x [99/Dec/9999:99:99:99 - end");
		// later bytes, zero and bracket included, must not disturb a good stamp
		push_text("[15/Jun/2012:08:09:10 ");
		push_byte(ltte_pkg::CH_NUL);
		push_byte(ltte_pkg::CH_LBRACK);
		push_byte(8'h7F);
		send_line();
	endtask

	task automatic test_each_month();
		for (int m = 0; m < 12; m++)
			send_text_line({"[", stamp_text(29, m, m % 2 ? 2023 : 2024, 23, 59, 59)});
	endtask

	task automatic test_malformed();
		send_text_line("GET /index.html");
		push_byte(ltte_pkg::CH_NUL);
		push_text("[01/Jan/2000:00:00:00 ");
		send_line();
		send_text_line("[01/Jan/2000:00:00");
		send_text_line("[01-Jan/2000:00:00:00 ");
		send_text_line("[0a/Jan/2000:00:00:00 ");
		push_text("[01/Jan/2000:00:00:00");
		push_byte(ltte_pkg::CH_NUL);
		send_line();
		send_text_line("[01/jan/2000:00:00:00 ");
		send_text_line("[01/Jan/2000:00:00:00x");
		send_text_line("[");
		send_text_line("ab[[01/Jan/2000:00:00:00 ");
	endtask

	task automatic test_output_hold();
		stall_pct = 0;
		gap_pct = 0;
		-> hold_go;
		// one-byte lines: every beat makes a result, so the pipeline fills fast
		repeat (30)
			send_beat(8'($urandom_range(255)), 1'b1);
		send_text_line("[28/Feb/2100:01:02:03 ");
	endtask

	task automatic run_phase(input int gap, input int stall);
		int first_beat;
		int first_line;
		gap_pct = gap;
		stall_pct = stall;
		first_beat = beats_sent;
		first_line = lines_sent;
		while (beats_sent - first_beat < 40 || lines_sent - first_line < 2)
			random_line();
	endtask

	task automatic test_random_traffic();
		run_phase(0, 0);
		run_phase(48, 0);
		run_phase(0, 48);
		run_phase(33, 33);
	endtask

	initial begin
		clear_parser();
		arst_n <= 1'b0;
		text_in.valid <= 1'b0;
		text_in.text_byte <= '0;
		text_in.line_end <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_known_stamps();
		test_each_month();
		test_malformed();
		test_output_hold();
		test_random_traffic();

		gap_pct = 0;
		stall_pct = 0;
		text_in.valid <= 1'b0;
		while (stamps_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d lines in %0d text beats; checked %0d results, %0d with a valid stamp.",
			lines_sent, beats_sent, stamps_checked, valid_stamps);
		$display("Idling: none, sender gaps, receiver stalls, both, plus one long output hold.");
		if (mismatch_count == 0) begin
			$display("log_timestamp_to_epoch test passed");
		end else begin
			$display("log_timestamp_to_epoch test failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d results still expected", stamps_due.size());
		$display("log_timestamp_to_epoch test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/ltte_pkg.sv
rtl/core/ltte_if.sv
rtl/core/ltte_parse.sv
rtl/core/ltte_calc.sv
rtl/core/log_timestamp_to_epoch.sv
verif/tb_log_timestamp_to_epoch.sv
